// ===== hdl/quantized_group_dot_product_assert.svh =====
// ----------------------------------------------------------------------------
// quantized_group_dot_product assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_GROUP_DOT_PRODUCT_ASSERT_SVH
`define QUANTIZED_GROUP_DOT_PRODUCT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition that holds at every edge out of reset
`define QGDP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// condition that forces a consequence at the following edge
`define QGDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QGDP_ASSERT_ALWAYS(label, expr, msg)
`define QGDP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/qgdp_pkg.sv =====
// ----------------------------------------------------------------------------
// qgdp_pkg
// Shared types and constants for the group-quantized dot product.
// ----------------------------------------------------------------------------
`default_nettype none

package qgdp_pkg;

  // weight format codes
  localparam logic [1:0] MODE_ASYM  = 2'd0;
  localparam logic [1:0] MODE_BIAS8 = 2'd1;
  localparam logic [1:0] MODE_INT8  = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_GIVEN   = 1'd1;

  // datapath widths
  localparam int ACT_W   = 16;
  localparam int PROD_W  = 24;
  localparam int PART_W  = 40;
  localparam int XSUM_W  = 32;
  localparam int TOTAL_W = 64;

  // input beat
  typedef struct packed {
    logic        [7:0]  weight_byte;
    logic signed [15:0] act_lo;
    logic signed [15:0] act_hi;
    logic               hi_valid;
    logic signed [15:0] group_scale;
    logic signed [15:0] group_min;
    logic signed [31:0] given_xsum;
    logic               last_of_group;
    logic               last_of_row;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [63:0] dot_result;
    logic               saturated;
  } out_beat_t;

  // lane products with the beat they came from
  typedef struct packed {
    logic signed [PROD_W-1:0] prod_lo;
    logic signed [PROD_W-1:0] prod_hi;
    in_beat_t                 beat;
  } lane_beat_t;

  // closed group handed to the row stage
  typedef struct packed {
    logic signed [PART_W-1:0] partial;
    logic signed [XSUM_W-1:0] xsum;
    logic signed [ACT_W-1:0]  scale;
    logic signed [ACT_W-1:0]  min_val;
    logic                     use_min;
    logic                     sat;
    logic                     last_of_row;
  } close_beat_t;

endpackage

`default_nettype wire

// ===== hdl/quantized_group_dot_product.sv =====
// ----------------------------------------------------------------------------
// quantized_group_dot_product
// Path to out_valid: lane, close, multiply, contribution and output registers.
// Throughput: one weight beat per cycle; the input stalls only while a
// group-closing beat waits behind a full output register.
// Reset clears the group and row accumulators and sets format_mode and
// use_given_xsum to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_group_dot_product (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire qgdp_pkg::in_beat_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output qgdp_pkg::out_beat_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [qgdp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [qgdp_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "quantized_group_dot_product_assert.svh"

  logic [1:0]                  format_mode;
  logic                        use_given_xsum;

  logic                        s1_valid;
  qgdp_pkg::in_beat_t          s1_reg;
  logic                        s1_load;
  logic                        s1_take;
  logic                        hi_keep;
  qgdp_pkg::lane_beat_t        lane_beat;

  logic                        close_valid;
  logic                        close_ready;
  qgdp_pkg::close_beat_t       close;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode    <= qgdp_pkg::MODE_ASYM;
      use_given_xsum <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qgdp_pkg::CFG_FORMAT_MODE: format_mode    <= cfg_data;
        qgdp_pkg::CFG_USE_GIVEN:   use_given_xsum <= cfg_data[0];
      endcase
    end
  end

  // lane stage beat
  assign in_stall = s1_valid && !s1_take;
  assign s1_load  = in_valid && !in_stall;
  assign hi_keep  = in_data.hi_valid && (format_mode == qgdp_pkg::MODE_ASYM
                                         || format_mode == qgdp_pkg::MODE_BIAS8);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_reg <= in_data;
    end
  end

  // low nibble or whole byte
  qgdp_lane u_lane_lo (
    .clk  (clk),
    .load (s1_load),
    .code (in_data.weight_byte),
    .mode (format_mode),
    .keep (1'b1),
    .act  (in_data.act_lo),
    .prod (lane_beat.prod_lo)
  );

  // high nibble
  qgdp_lane u_lane_hi (
    .clk  (clk),
    .load (s1_load),
    .code ({4'b0, in_data.weight_byte[7:4]}),
    .mode (format_mode),
    .keep (hi_keep),
    .act  (in_data.act_hi),
    .prod (lane_beat.prod_hi)
  );

  assign lane_beat.beat = s1_reg;

  qgdp_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .mode        (format_mode),
    .use_given   (use_given_xsum),
    .lane_valid  (s1_valid),
    .lane        (lane_beat),
    .lane_take   (s1_take),
    .close_valid (close_valid),
    .close       (close),
    .close_ready (close_ready)
  );

  qgdp_row u_row (
    .clk         (clk),
    .rst         (rst),
    .close_valid (close_valid),
    .close       (close),
    .close_ready (close_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // only a group-closing beat can back up the input
  `QGDP_ASSERT_ALWAYS(a_stall_only_on_close, !in_stall || (s1_valid && (s1_reg.last_of_group || s1_reg.last_of_row)), "input stalled by a non-closing beat")
  // a lane beat that is not taken stays put
  `QGDP_ASSERT_NEXT(a_lane_hold, s1_valid && !s1_take, s1_valid && $stable(s1_reg), "lane beat lost while waiting")
  // a closed group that is not taken stays put
  `QGDP_ASSERT_NEXT(a_close_hold, close_valid && !close_ready, close_valid && $stable(close), "closed group lost while waiting")

endmodule

`default_nettype wire

// ===== hdl/qgdp_lane.sv =====
// ----------------------------------------------------------------------------
// qgdp_lane
// One weight lane: decodes a nibble or byte and registers weight * activation.
// ----------------------------------------------------------------------------
`default_nettype none

module qgdp_lane (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [7:0]                         code,
  input  wire logic [1:0]                         mode,
  input  wire logic                               keep,
  input  wire logic signed [qgdp_pkg::ACT_W-1:0]  act,
  output logic signed [qgdp_pkg::PROD_W-1:0]      prod
);

  logic signed [8:0]                    weight;
  logic signed [qgdp_pkg::PROD_W:0]     prod_full;

  // weight decode per format
  always_comb begin
    unique case (mode)
      qgdp_pkg::MODE_ASYM:  weight = $signed({5'b0, code[3:0]});
      qgdp_pkg::MODE_BIAS8: weight = $signed({5'b0, code[3:0]}) - 9'sd8;
      default:              weight = $signed({code[7], code});
    endcase
    if (!keep) begin
      weight = '0;
    end
  end

  // magnitude stays within 2^22, the top bit is only sign
  assign prod_full = (qgdp_pkg::PROD_W+1)'(weight) * (qgdp_pkg::PROD_W+1)'(act);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_full[qgdp_pkg::PROD_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qgdp_accum.sv =====
// ----------------------------------------------------------------------------
// qgdp_accum
// Merges the lane products into the saturating group partial and activation
// sum, and hands each closed group to the row stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qgdp_accum (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [1:0]            mode,
  input  wire logic                  use_given,
  input  wire logic                  lane_valid,
  input  wire qgdp_pkg::lane_beat_t  lane,
  output logic                       lane_take,
  output logic                       close_valid,
  output qgdp_pkg::close_beat_t      close,
  input  wire logic                  close_ready
);

  localparam int PW = qgdp_pkg::PART_W;
  localparam int XW = qgdp_pkg::XSUM_W;

  logic signed [PW-1:0]         part;
  logic signed [XW-1:0]         xsum;
  logic                         grp_sat;

  logic                         closing;
  logic signed [qgdp_pkg::PROD_W:0] prod_sum;
  logic signed [PW:0]           part_sum;
  logic signed [PW-1:0]         part_next;
  logic                         part_ovf;
  logic                         acc_act;
  logic signed [XW+1:0]         xsum_sum;
  logic signed [XW-1:0]         xsum_next;
  logic                         xsum_ovf;
  logic                         grp_sat_next;
  qgdp_pkg::close_beat_t        close_next;

  assign closing   = lane.beat.last_of_group || lane.beat.last_of_row;
  assign lane_take = lane_valid && (!closing || !close_valid || close_ready);

  // merge the lanes and clamp the group partial
  always_comb begin
    prod_sum = (qgdp_pkg::PROD_W+1)'(lane.prod_lo) + (qgdp_pkg::PROD_W+1)'(lane.prod_hi);
    part_sum = (PW+1)'(part) + (PW+1)'(prod_sum);
    part_ovf = part_sum[PW] != part_sum[PW-1];
    if (part_ovf) begin
      part_next = part_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      part_next = part_sum[PW-1:0];
    end
  end

  // activation sum, asymmetric format only, unless the given sum is used
  always_comb begin
    acc_act  = (mode == qgdp_pkg::MODE_ASYM) && !use_given;
    xsum_sum = (XW+2)'(xsum) + (XW+2)'(lane.beat.act_lo)
             + (lane.beat.hi_valid ? (XW+2)'(lane.beat.act_hi) : '0);
    xsum_ovf = 1'b0;
    xsum_next = xsum;
    if (acc_act) begin
      if (xsum_sum > (XW+2)'(signed'({1'b0, {(XW-1){1'b1}}}))) begin
        xsum_ovf  = 1'b1;
        xsum_next = {1'b0, {(XW-1){1'b1}}};
      end else if (xsum_sum < (XW+2)'(signed'({1'b1, {(XW-1){1'b0}}}))) begin
        xsum_ovf  = 1'b1;
        xsum_next = {1'b1, {(XW-1){1'b0}}};
      end else begin
        xsum_next = xsum_sum[XW-1:0];
      end
    end
    grp_sat_next = grp_sat || part_ovf || xsum_ovf;
  end

  // closed group beat
  always_comb begin
    close_next.partial     = part_next;
    close_next.xsum        = use_given ? lane.beat.given_xsum : xsum_next;
    close_next.scale       = lane.beat.group_scale;
    close_next.min_val     = lane.beat.group_min;
    close_next.use_min     = mode == qgdp_pkg::MODE_ASYM;
    close_next.sat         = grp_sat_next;
    close_next.last_of_row = lane.beat.last_of_row;
  end

  // group accumulators and close handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      part        <= '0;
      xsum        <= '0;
      grp_sat     <= 1'b0;
      close_valid <= 1'b0;
    end else begin
      if (close_valid && close_ready) begin
        close_valid <= 1'b0;
      end
      if (lane_take) begin
        if (closing) begin
          part        <= '0;
          xsum        <= '0;
          grp_sat     <= 1'b0;
          close_valid <= 1'b1;
        end else begin
          part    <= part_next;
          xsum    <= xsum_next;
          grp_sat <= grp_sat_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lane_take && closing) begin
      close <= close_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qgdp_row.sv =====
// ----------------------------------------------------------------------------
// qgdp_row
// Scales each closed group, adds the min term and folds it into the
// saturating row total; emits the row result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qgdp_row (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   close_valid,
  input  wire qgdp_pkg::close_beat_t  close,
  output logic                        close_ready,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output qgdp_pkg::out_beat_t         out_data
);

  localparam int PW  = qgdp_pkg::PART_W;
  localparam int XW  = qgdp_pkg::XSUM_W;
  localparam int AW  = qgdp_pkg::ACT_W;
  localparam int TW  = qgdp_pkg::TOTAL_W;
  localparam int MAW = PW + AW;
  localparam int MBW = XW + AW;
  localparam int CW  = MAW + 1;

  // multiply stage
  logic                   m_valid;
  logic signed [MAW-1:0]  m_prod_a;
  logic signed [MBW-1:0]  m_prod_b;
  logic                   m_sat;
  logic                   m_eor;

  // contribution stage
  logic                   c_valid;
  logic signed [CW-1:0]   c_contrib;
  logic                   c_sat;
  logic                   c_eor;

  // row accumulator
  logic signed [TW-1:0]   row_total;
  logic                   row_sat;

  logic                   out_free;
  logic                   c_drain;
  logic                   c_ready;
  logic                   m_ready;
  logic signed [TW:0]     row_sum;
  logic                   row_ovf;
  logic signed [TW-1:0]   row_total_next;
  logic                   row_sat_next;

  // back-pressure chain
  assign out_free    = !out_valid || !out_stall;
  assign c_drain     = c_valid && (!c_eor || out_free);
  assign c_ready     = !c_valid || c_drain;
  assign m_ready     = !m_valid || c_ready;
  assign close_ready = m_ready;

  // saturating row add
  always_comb begin
    row_sum = (TW+1)'(row_total) + (TW+1)'(c_contrib);
    row_ovf = row_sum[TW] != row_sum[TW-1];
    if (row_ovf) begin
      row_total_next = row_sum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      row_total_next = row_sum[TW-1:0];
    end
    row_sat_next = row_sat || c_sat || row_ovf;
  end

  // control and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
      row_total <= '0;
      row_sat   <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid <= close_valid;
      end
      if (c_ready) begin
        c_valid <= m_valid;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (c_drain) begin
        if (c_eor) begin
          row_total <= '0;
          row_sat   <= 1'b0;
          out_valid <= 1'b1;
        end else begin
          row_total <= row_total_next;
          row_sat   <= row_sat_next;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (m_ready && close_valid) begin
      m_prod_a <= MAW'($signed(close.partial)) * MAW'($signed(close.scale));
      m_prod_b <= close.use_min ? MBW'($signed(close.min_val)) * MBW'($signed(close.xsum))
                                : '0;
      m_sat    <= close.sat;
      m_eor    <= close.last_of_row;
    end
    if (c_ready && m_valid) begin
      c_contrib <= CW'(m_prod_a) + CW'(m_prod_b);
      c_sat     <= m_sat;
      c_eor     <= m_eor;
    end
    if (c_drain && c_eor) begin
      out_data.dot_result <= row_total_next;
      out_data.saturated  <= row_sat_next;
    end
  end

endmodule

`default_nettype wire
